// ----- design/mtrd_pkg.sv -----
// ---------------------------------------------------------------------------
// mtrd_pkg: shared types and constants for the ranged draw generator
// Twister constants, action codes and the sequencer state type.
// ---------------------------------------------------------------------------
package mtrd_pkg;

    localparam int unsigned N_WORDS = 624;
    localparam int unsigned M_OFF   = 397;
    localparam int unsigned IDX_W   = 10;

    localparam logic [31:0] MATRIX_A      = 32'h9908b0df;
    localparam logic [31:0] TEMPER_B      = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_C      = 32'hefc60000;
    localparam logic [31:0] INIT_MULT     = 32'd1812433253;
    localparam logic [31:0] DEFAULT_SEED  = 32'd4357;
    localparam logic [31:0] HIGH_BIT_MASK = 32'h80000000;
    localparam logic [31:0] LOW_BITS_MASK = 32'h7fffffff;
    localparam logic [31:0] FULL_WORD     = 32'hffffffff;

    localparam logic [1:0] ACT_RESEED = 2'd0;
    localparam logic [1:0] ACT_RAW    = 2'd1;
    localparam logic [1:0] ACT_RANGED = 2'd2;

    typedef enum logic [4:0] {
        ST_FILL,     // write fill word, compute next
        ST_FMUL,     // fill stage: add index to product
        ST_IDLE,
        ST_TW_RD0,   // twist: issue read k
        ST_TW_RD1,   // twist: issue read k+1
        ST_TW_RD2,   // twist: issue read k+M
        ST_TW_WAIT,
        ST_TW_WR,
        ST_DRAW_RD,
        ST_DRAW_WAIT,
        ST_TEMPER,
        ST_DIV_SCALE,
        ST_DIV_Q,
        ST_CHECK,
        ST_OUT
    } state_t;

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] k;
        k = w ^ (w >> 11);
        k = k ^ ((k << 7) & TEMPER_B);
        k = k ^ ((k << 15) & TEMPER_C);
        k = k ^ (k >> 18);
        return k;
    endfunction

    function automatic logic [31:0] mix(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] far);
        logic [31:0] y;
        y = (a & HIGH_BIT_MASK) | (b & LOW_BITS_MASK);
        return far ^ (y >> 1) ^ (y[0] ? MATRIX_A : 32'd0);
    endfunction

endpackage

// ----- design/mersenne_twister_ranged_draw_core.sv -----
// ---------------------------------------------------------------------------
// mersenne_twister_ranged_draw_core: MT19937 generator with ranged draws
// State in one 624x32 synchronous RAM, driven by a read-modify-write sequencer.
// ---------------------------------------------------------------------------
// One item at a time. After reset and after every reseed item a fill pass
// writes the 624 state words, during which no item is taken. The first
// draw after a fill runs the batch twist through the single RAM port.
// A raw draw otherwise reads its word, waits for the RAM and tempers it into
// the output register; the next item is only taken once the result is taken.
// A ranged draw runs the radix-2 divider once for the scale, then for each
// drawn word reads, tempers, forms the quotient and checks it; each rejection
// draws another word. The result waits in an output register until taken.
module mersenne_twister_ranged_draw_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [31:0] lower,
    input  logic [31:0] upper,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] value,
    output logic        bad_range,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    localparam logic [9:0] LAST = 10'(mtrd_pkg::N_WORDS - 1);
    localparam logic [9:0] NW   = 10'(mtrd_pkg::N_WORDS);
    localparam logic [9:0] MO   = 10'(mtrd_pkg::M_OFF);

    // state RAM
    logic [31:0] mem [0:mtrd_pkg::N_WORDS-1];
    logic        mem_we;
    logic [9:0]  mem_addr;
    logic [31:0] mem_wdata;
    logic [31:0] mem_rdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        mem_rdata <= mem[mem_addr];
    end

    mtrd_pkg::state_t state_reg, state_next;
    logic [31:0] seed_reg;
    logic [9:0]  idx_reg, idx_next;      // word index / fill pointer
    logic [9:0]  k_reg, k_next;          // twist pointer
    logic [31:0] a_reg, a_next, b_reg, b_next, w_reg, w_next;
    logic [1:0]  act_reg, act_next;
    logic [31:0] lo_reg, lo_next, n_reg, n_next, scale_reg, scale_next;
    logic [31:0] quo_reg, quo_next, rem_reg, rem_next, dvd_reg, dvd_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        ovalid_reg, ovalid_next;
    logic [31:0] oval_reg, oval_next;
    logic        obad_reg, obad_next;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != mtrd_pkg::ST_IDLE) || ovalid_reg;
    assign out_valid = ovalid_reg;
    assign value     = oval_reg;
    assign bad_range = obad_reg;

    // divider step: one quotient bit per cycle
    logic [32:0] rem_sh;
    logic        rem_ge;
    logic [31:0] div_d;
    assign div_d  = (state_reg == mtrd_pkg::ST_DIV_SCALE) ? n_reg : scale_reg;
    assign rem_sh = {rem_reg, dvd_reg[31]};
    assign rem_ge = rem_sh >= {1'b0, div_d};

    // fill recurrence operand: w xor (w >> 30)
    logic [31:0] fill_x;
    assign fill_x = w_reg ^ (w_reg >> 30);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= mtrd_pkg::ST_FILL;
            seed_reg   <= mtrd_pkg::DEFAULT_SEED;
            idx_reg    <= '0;
            w_reg      <= mtrd_pkg::DEFAULT_SEED;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            w_reg      <= w_next;
            ovalid_reg <= ovalid_next;
            if (cfg_valid && cfg_ready)
                seed_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg     <= k_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        act_reg   <= act_next;
        lo_reg    <= lo_next;
        n_reg     <= n_next;
        scale_reg <= scale_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        dvd_reg   <= dvd_next;
        cnt_reg   <= cnt_next;
        oval_reg  <= oval_next;
        obad_reg  <= obad_next;
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        k_next      = k_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        w_next      = w_reg;
        act_next    = act_reg;
        lo_next     = lo_reg;
        n_next      = n_reg;
        scale_next  = scale_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        dvd_next    = dvd_reg;
        cnt_next    = cnt_reg;
        ovalid_next = ovalid_reg;
        oval_next   = oval_reg;
        obad_next   = obad_reg;
        mem_we      = 1'b0;
        mem_addr    = idx_reg;
        mem_wdata   = w_reg;

        if (ovalid_reg && !out_stall)
            ovalid_next = 1'b0;

        unique case (state_reg)
            // write word idx, then form the next one
            mtrd_pkg::ST_FILL:
            begin
                mem_we   = 1'b1;
                mem_addr = idx_reg;
                if (idx_reg == LAST)
                begin
                    idx_next   = NW;
                    state_next = mtrd_pkg::ST_IDLE;
                end
                else
                begin
                    a_next     = mtrd_pkg::INIT_MULT * fill_x;
                    state_next = mtrd_pkg::ST_FMUL;
                end
            end
            mtrd_pkg::ST_FMUL:
            begin
                w_next     = a_reg + 32'(idx_reg + 10'd1);
                idx_next   = idx_reg + 10'd1;
                state_next = mtrd_pkg::ST_FILL;
            end
            mtrd_pkg::ST_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    act_next = action;
                    lo_next  = lower;
                    n_next   = upper - lower;
                    if (action == mtrd_pkg::ACT_RESEED)
                    begin
                        w_next     = (seed_reg == 32'd0) ? mtrd_pkg::DEFAULT_SEED : seed_reg;
                        idx_next   = '0;
                        oval_next  = '0;
                        obad_next  = 1'b0;
                        ovalid_next = 1'b1;
                        state_next = mtrd_pkg::ST_FILL;
                    end
                    else if (action == mtrd_pkg::ACT_RAW)
                        state_next = (idx_reg >= NW) ? mtrd_pkg::ST_TW_RD0
                                                     : mtrd_pkg::ST_DRAW_RD;
                    else if (action == mtrd_pkg::ACT_RANGED && upper > lower)
                    begin
                        dvd_next   = mtrd_pkg::FULL_WORD;
                        rem_next   = '0;
                        cnt_next   = '0;
                        state_next = mtrd_pkg::ST_DIV_SCALE;
                    end
                    else
                    begin
                        oval_next   = '0;
                        obad_next   = (action == mtrd_pkg::ACT_RANGED);
                        ovalid_next = 1'b1;
                    end
                    k_next = '0;
                end
            end
            // batch twist, one word per pass; each read is registered and lands in the next state
            mtrd_pkg::ST_TW_RD0:
            begin
                mem_addr   = k_reg;
                state_next = mtrd_pkg::ST_TW_RD1;
            end
            mtrd_pkg::ST_TW_RD1:
            begin
                a_next     = mem_rdata;
                mem_addr   = (k_reg == LAST) ? 10'd0 : k_reg + 10'd1;
                state_next = mtrd_pkg::ST_TW_RD2;
            end
            mtrd_pkg::ST_TW_RD2:
            begin
                b_next     = mem_rdata;
                mem_addr   = (k_reg >= NW - MO) ? k_reg - (NW - MO) : k_reg + MO;
                state_next = mtrd_pkg::ST_TW_WAIT;
            end
            mtrd_pkg::ST_TW_WAIT:
            begin
                w_next     = mem_rdata;
                state_next = mtrd_pkg::ST_TW_WR;
            end
            mtrd_pkg::ST_TW_WR:
            begin
                mem_we    = 1'b1;
                mem_addr  = k_reg;
                mem_wdata = mtrd_pkg::mix(a_reg, b_reg, w_reg);
                if (k_reg == LAST)
                begin
                    idx_next   = '0;
                    state_next = mtrd_pkg::ST_DRAW_RD;
                end
                else
                begin
                    k_next     = k_reg + 10'd1;
                    state_next = mtrd_pkg::ST_TW_RD0;
                end
            end
            mtrd_pkg::ST_DRAW_RD:
            begin
                mem_addr   = idx_reg;
                state_next = mtrd_pkg::ST_DRAW_WAIT;
            end
            mtrd_pkg::ST_DRAW_WAIT:
                state_next = mtrd_pkg::ST_TEMPER;
            mtrd_pkg::ST_TEMPER:
            begin
                w_next   = mtrd_pkg::temper(mem_rdata);
                idx_next = idx_reg + 10'd1;
                if (act_reg == mtrd_pkg::ACT_RAW)
                begin
                    oval_next   = mtrd_pkg::temper(mem_rdata);
                    obad_next   = 1'b0;
                    ovalid_next = 1'b1;
                    state_next  = mtrd_pkg::ST_IDLE;
                end
                else
                begin
                    dvd_next   = mtrd_pkg::temper(mem_rdata);
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = mtrd_pkg::ST_DIV_Q;
                end
            end
            // restoring division, scale = FULL / n, then q = word / scale
            mtrd_pkg::ST_DIV_SCALE, mtrd_pkg::ST_DIV_Q:
            begin
                rem_next = rem_ge ? 32'(rem_sh - {1'b0, div_d}) : rem_sh[31:0];
                quo_next = {quo_reg[30:0], rem_ge};
                dvd_next = {dvd_reg[30:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    if (state_reg == mtrd_pkg::ST_DIV_SCALE)
                    begin
                        scale_next = {quo_reg[30:0], rem_ge};
                        state_next = (idx_reg >= NW) ? mtrd_pkg::ST_TW_RD0
                                                     : mtrd_pkg::ST_DRAW_RD;
                    end
                    else
                        state_next = mtrd_pkg::ST_CHECK;
                end
            end
            mtrd_pkg::ST_CHECK:
            begin
                if (quo_reg >= n_reg)
                begin
                    k_next     = '0;
                    state_next = (idx_reg >= NW) ? mtrd_pkg::ST_TW_RD0
                                                 : mtrd_pkg::ST_DRAW_RD;
                end
                else
                begin
                    oval_next  = lo_reg + quo_reg;
                    obad_next  = 1'b0;
                    state_next = mtrd_pkg::ST_OUT;
                end
            end
            mtrd_pkg::ST_OUT:
            begin
                if (!ovalid_reg)
                begin
                    ovalid_next = 1'b1;
                    state_next  = mtrd_pkg::ST_IDLE;
                end
            end
            default:
                state_next = mtrd_pkg::ST_IDLE;
        endcase
    end

endmodule

// ----- verif/tb_mersenne_twister_ranged_draw_core.sv -----
// ---------------------------------------------------------------------------
// tb_mersenne_twister_ranged_draw_core: self-checking bench for the MT19937 core
// Drives reseed, raw and ranged draw words under random idling and back
// pressure. A scoreboard with its own twister predicts each result word.
// ---------------------------------------------------------------------------
module tb_mersenne_twister_ranged_draw_core;

    localparam int unsigned MAX_CYCLES = 3000000;
    localparam int unsigned SETTLE     = 1500;   // covers a fill pass after reseed
    localparam logic [1:0]  ACT_SPARE  = 2'd3;   // unused action code

    // Scoreboard: twister predictor plus queue of expected words
    class draw_scoreboard;
        logic [31:0] seed_reg;
        logic [31:0] mt[mtrd_pkg::N_WORDS];
        int unsigned pos;
        logic [31:0] exp_value[$];
        logic        exp_bad[$];
        int unsigned errors;

        function new();
            seed_reg = mtrd_pkg::DEFAULT_SEED;
            errors   = 0;
            refill();
        endfunction

        function void refill();
            logic [31:0] p;
            mt[0] = (seed_reg == 32'd0) ? mtrd_pkg::DEFAULT_SEED : seed_reg;
            for (int i = 1; i < mtrd_pkg::N_WORDS; i++)
            begin
                p     = mt[i-1];
                mt[i] = mtrd_pkg::INIT_MULT * (p ^ (p >> 30)) + 32'(i);
            end
            pos = mtrd_pkg::N_WORDS;
        endfunction

        function logic [31:0] blend(logic [31:0] a, logic [31:0] b, logic [31:0] far);
            logic [31:0] y;
            y = {a[31], b[30:0]};
            return far ^ {1'b0, y[31:1]} ^ ({32{y[0]}} & mtrd_pkg::MATRIX_A);
        endfunction

        function void regenerate();
            for (int k = 0; k < mtrd_pkg::N_WORDS - 1; k++)
                mt[k] = blend(mt[k], mt[k+1],
                              mt[(k + mtrd_pkg::M_OFF) % mtrd_pkg::N_WORDS]);
            mt[mtrd_pkg::N_WORDS-1] = blend(mt[mtrd_pkg::N_WORDS-1], mt[0],
                                            mt[mtrd_pkg::M_OFF-1]);
            pos = 0;
        endfunction

        function logic [31:0] draw_tempered();
            logic [31:0] t;
            if (pos >= mtrd_pkg::N_WORDS)
                regenerate();
            t = mt[pos];
            t = t ^ (t >> 11);
            t = t ^ ((t << 7) & mtrd_pkg::TEMPER_B);
            t = t ^ ((t << 15) & mtrd_pkg::TEMPER_C);
            t = t ^ (t >> 18);
            pos++;
            return t;
        endfunction

        // accepted input word: compute and queue its result
        function void note_input(logic [1:0] act, logic [31:0] lo, logic [31:0] hi);
            logic [31:0] v, span, scale, q;
            logic        bad;
            v   = 32'd0;
            bad = 1'b0;
            if (act == mtrd_pkg::ACT_RESEED)
                refill();
            else if (act == mtrd_pkg::ACT_RAW)
                v = draw_tempered();
            else if (act == mtrd_pkg::ACT_RANGED)
            begin
                if (hi <= lo)
                    bad = 1'b1;
                else
                begin
                    span  = hi - lo;
                    scale = mtrd_pkg::FULL_WORD / span;
                    do
                        q = draw_tempered() / scale;
                    while (q >= span);
                    v = lo + q;
                end
            end
            exp_value.push_back(v);
            exp_bad.push_back(bad);
        endfunction

        function void check_result(logic [31:0] v, logic bad);
            logic [31:0] ev;
            logic        eb;
            if (exp_value.size() == 0)
            begin
                $error("unexpected result word: value %h bad_range %b", v, bad);
                errors++;
                return;
            end
            ev = exp_value.pop_front();
            eb = exp_bad.pop_front();
            if (v !== ev)
            begin
                $error("value mismatch: expected %h, actual %h", ev, v);
                errors++;
            end
            if (bad !== eb)
            begin
                $error("bad_range mismatch: expected %b, actual %b", eb, bad);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return exp_value.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  action;
    logic [31:0] lower;
    logic [31:0] upper;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] value;
    logic        bad_range;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    draw_scoreboard sb;
    bit          idling_on;
    bit          hold_request;
    int unsigned cycle_count = 0;

    mersenne_twister_ranged_draw_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .lower     (lower),
        .upper     (upper),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .bad_range (bad_range),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock, period 4
    initial
    begin
        clk = 1'b0;
    end
    always #2 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold on request
    initial
    begin
        int unsigned burst;
        bit          held;
        held      = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                sb.check_result(value, bad_range);
            if (hold_request && !held)
            begin
                out_stall <= 1'b1;
                held      = 1'b1;
                repeat (600) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                burst = $urandom_range(1, 17);
                repeat (burst) @(posedge clk);
                if (out_valid && !out_stall)
                    sb.check_result(value, bad_range);
                out_stall <= 1'b0;
            end
        end
    end

    // offer one word; valid stays high unless a gap follows
    task automatic send_word(logic [1:0] act, logic [31:0] lo, logic [31:0] hi);
        in_valid <= 1'b1;
        action   <= act;
        lower    <= lo;
        upper    <= hi;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(act, lo, hi);
        if (idling_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_seed(logic [31:0] s);
        cfg_valid <= 1'b1;
        cfg_data  <= s;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.seed_reg = s;
    endtask

    task automatic random_words(int unsigned count);
        int unsigned pick;
        logic [31:0] lo, span;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            lo   = $urandom;
            if (pick < 2)
                send_word(mtrd_pkg::ACT_RESEED, $urandom, $urandom);
            else if (pick < 4)
                send_word(ACT_SPARE, $urandom, $urandom);
            else if (pick < 34)
                send_word(mtrd_pkg::ACT_RAW, $urandom, $urandom);
            else if (pick < 54)
            begin
                // narrow span
                span = $urandom_range(1, 200);
                lo   = $urandom_range(0, 32'hffffff00);
                send_word(mtrd_pkg::ACT_RANGED, lo, lo + span);
            end
            else if (pick < 64)
            begin
                // wide span, from about half to the full word range
                span = $urandom_range(32'h7fff0000, 32'hffffffff);
                lo   = $urandom_range(0, ~span);
                send_word(mtrd_pkg::ACT_RANGED, lo, lo + span);
            end
            else if (pick < 92)
                send_word(mtrd_pkg::ACT_RANGED, $urandom, $urandom);
            else
                send_word(mtrd_pkg::ACT_RANGED, lo, lo - $urandom_range(0, 3));
        end
    endtask

    // main sequence
    initial
    begin
        sb           = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = mtrd_pkg::ACT_RAW;
        lower        = 32'd0;
        upper        = 32'd0;
        cfg_valid    = 1'b0;
        cfg_data     = 32'd0;
        idling_on    = 1'b0;
        hold_request = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset seed, every action, range extremes
        send_word(mtrd_pkg::ACT_RAW, 32'd0, 32'd0);
        send_word(mtrd_pkg::ACT_RAW, 32'hffffffff, 32'hffffffff);
        send_word(mtrd_pkg::ACT_RANGED, 32'd0, 32'hffffffff);
        send_word(mtrd_pkg::ACT_RANGED, 32'hfffffffe, 32'hffffffff);
        send_word(mtrd_pkg::ACT_RANGED, 32'd0, 32'd1);
        send_word(mtrd_pkg::ACT_RANGED, 32'd0, 32'h80000001);
        send_word(mtrd_pkg::ACT_RANGED, 32'h7fffffff, 32'hffffffff);
        send_word(mtrd_pkg::ACT_RANGED, 32'd5, 32'd5);
        send_word(mtrd_pkg::ACT_RANGED, 32'hffffffff, 32'd0);
        send_word(mtrd_pkg::ACT_RANGED, 32'd0, 32'd0);
        send_word(mtrd_pkg::ACT_RANGED, 32'hffffffff, 32'hffffffff);
        send_word(ACT_SPARE, 32'hffffffff, 32'hffffffff);
        send_word(mtrd_pkg::ACT_RESEED, 32'd0, 32'd0);
        send_word(mtrd_pkg::ACT_RAW, 32'd0, 32'd0);
        drain();

        // seed zero falls back to the default
        write_seed(32'd0);
        send_word(mtrd_pkg::ACT_RESEED, 32'd0, 32'd0);
        idling_on = 1'b1;
        random_words(300);
        drain();

        // all-ones seed, with a long output hold
        write_seed(32'hffffffff);
        send_word(mtrd_pkg::ACT_RESEED, 32'd0, 32'd0);
        hold_request = 1'b1;
        random_words(350);
        drain();

        write_seed($urandom);
        send_word(mtrd_pkg::ACT_RESEED, 32'd0, 32'd0);
        random_words(350);
        drain();

        // last stretch without idling
        write_seed(32'd1);
        send_word(mtrd_pkg::ACT_RESEED, 32'd0, 32'd0);
        idling_on = 1'b0;
        random_words(320);
        drain();

        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/mtrd_pkg.sv
design/mersenne_twister_ranged_draw_core.sv
verif/tb_mersenne_twister_ranged_draw_core.sv
